### rtl/wfs_pkg.sv
`timescale 1ns / 1ps
package wfs_pkg;

    localparam int COORD_W   = 32;
    localparam int CFG_W     = 31;
    localparam int CMD_W     = 2;
    localparam int ST_W      = 3;
    localparam int IDX_OUT_W = 7;
    localparam int CFG_IDX_W = 2;

    localparam int PATH_DEPTH_DEF = 64;

    // arithmetic widths
    localparam int AD_W    = 32;   // |waypoint - position|
    localparam int DSQ_W   = 66;   // sum of three squares
    localparam int ROOT_W  = 34;   // floor(sqrt(dsq))
    localparam int OP_W    = 34;   // multiplier operand
    localparam int PROD_W  = 2 * OP_W;
    localparam int SQ_REM_W = 38;
    localparam int STEP_HI = 2 * CFG_W - 1;
    localparam int STEP_W  = STEP_HI - 16 + 1;
    localparam int ITER_N  = 34;   // iterations of square root and divide
    localparam int ITER_CW = 6;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [ST_W-1:0] ST_NO_PATH  = 3'd0;
    localparam logic [ST_W-1:0] ST_MOVED    = 3'd1;
    localparam logic [ST_W-1:0] ST_REACHED  = 3'd2;
    localparam logic [ST_W-1:0] ST_FINISHED = 3'd3;
    localparam logic [ST_W-1:0] ST_STORED   = 3'd4;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd5;
    localparam logic [ST_W-1:0] ST_CLEARED  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICK   = 2'd2;

    localparam logic [CFG_W-1:0] RADIUS_RST = 31'd65536;
    localparam logic [CFG_W-1:0] SPEED_RST  = 31'd65536;
    localparam logic [CFG_W-1:0] TICK_RST   = 31'd1092;

    localparam logic [1:0] MUL_SQ   = 2'd0;
    localparam logic [1:0] MUL_R2   = 2'd1;
    localparam logic [1:0] MUL_STEP = 2'd2;
    localparam logic [1:0] MUL_MOVE = 2'd3;

    typedef struct packed {
        logic            load_in;
        logic            rd_wp;
        logic            lat_diff;
        logic            mul_en;
        logic [1:0]      mul_sel;
        logic            acc_en;
        logic            k_rst;
        logic            k_inc;
        logic            sqrt_start;
        logic            clamp_en;
        logic            div_start;
        logic            div_store;
        logic            do_clear;
        logic            do_append;
        logic            idx_inc;
        logic            st_en;
        logic [ST_W-1:0] st_val;
        logic            out_load;
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             has_path;
        logic             full;
        logic             idx_ge_cnt;
        logic             reached;
        logic             last;
        logic             k_last;
        logic             sqrt_busy;
        logic             div_busy;
        logic             out_busy;
    } t_sts;

endpackage

### rtl/wfs_isqrt.sv
`timescale 1ns / 1ps
module wfs_isqrt import wfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DSQ_W-1:0]  i_val,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    logic [2*ITER_N-1:0] r_v;
    logic [SQ_REM_W-1:0] r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [ITER_CW-1:0]  r_cnt;
    logic [SQ_REM_W-1:0] w_rem4;
    logic [SQ_REM_W-1:0] w_trial;

    // bring down two bits, try root*4+1
    assign w_rem4  = {r_rem[SQ_REM_W-3:0], r_v[2*ITER_N-1 -: 2]};
    assign w_trial = {{(SQ_REM_W-ROOT_W-2){1'b0}}, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= ITER_CW'(ITER_N);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= {{(2*ITER_N-DSQ_W){1'b0}}, i_val};
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_v <= {r_v[2*ITER_N-3:0], 2'b00};
            if (w_rem4 >= w_trial) begin
                r_rem  <= w_rem4 - w_trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem4;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_root = r_root;

endmodule

### rtl/wfs_div.sv
`timescale 1ns / 1ps
module wfs_div import wfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num,
    input  logic [ROOT_W-1:0] i_den,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_quo
);

    // quotient is known to fit ITER_N bits, so the upper half starts as remainder
    logic [ROOT_W-1:0]  r_rem;
    logic [ITER_N-1:0]  r_lo;
    logic [ROOT_W-1:0]  r_den;
    logic [ROOT_W-1:0]  r_quo;
    logic [ITER_CW-1:0] r_cnt;
    logic [ROOT_W:0]    w_rem2;
    logic [ROOT_W:0]    w_sub;

    assign w_rem2 = {r_rem, r_lo[ITER_N-1]};
    assign w_sub  = w_rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= ITER_CW'(ITER_N);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[PROD_W-1 -: ROOT_W];
            r_lo  <= i_num[ITER_N-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_lo <= {r_lo[ITER_N-2:0], 1'b0};
            if (w_rem2 >= {1'b0, r_den}) begin
                r_rem <= w_sub[ROOT_W-1:0];
                r_quo <= {r_quo[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem2[ROOT_W-1:0];
                r_quo <= {r_quo[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

### rtl/wfs_ctrl.sv
`timescale 1ns / 1ps
module wfs_ctrl import wfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_DIFF = 4'd2;
    localparam logic [3:0] S_MSQ  = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_MR2  = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_STEP = 4'd7;
    localparam logic [3:0] S_SQW  = 4'd8;
    localparam logic [3:0] S_MMV  = 4'd9;
    localparam logic [3:0] S_DIVS = 4'd10;
    localparam logic [3:0] S_DIVW = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state      = S_OUT;
                o_cmd.st_en  = 1'b1;
                o_cmd.st_val = ST_NO_PATH;
                if (i_sts.cmd == CMD_CLEAR) begin
                    o_cmd.do_clear = 1'b1;
                    o_cmd.st_val   = ST_CLEARED;
                end else if (i_sts.cmd == CMD_APPEND) begin
                    o_cmd.do_append = !i_sts.full;
                    o_cmd.st_val    = i_sts.full ? ST_FULL : ST_STORED;
                end else if (i_sts.cmd == CMD_TICK && i_sts.has_path) begin
                    if (i_sts.idx_ge_cnt) begin
                        o_cmd.do_clear = 1'b1;
                        o_cmd.st_val   = ST_FINISHED;
                    end else begin
                        o_cmd.st_en = 1'b0;
                        o_cmd.rd_wp = 1'b1;
                        o_cmd.k_rst = 1'b1;
                        n_state     = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                o_cmd.lat_diff = 1'b1;
                n_state = S_MSQ;
            end
            S_MSQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SQ;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_MR2;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_MSQ;
                end
            end
            S_MR2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_R2;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.reached) begin
                    o_cmd.idx_inc  = 1'b1;
                    o_cmd.do_clear = i_sts.last;
                    o_cmd.st_en    = 1'b1;
                    o_cmd.st_val   = i_sts.last ? ST_FINISHED : ST_REACHED;
                    n_state = S_OUT;
                end else begin
                    o_cmd.sqrt_start = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_STEP;
                n_state = S_SQW;
            end
            S_SQW: begin
                if (!i_sts.sqrt_busy) begin
                    o_cmd.clamp_en = 1'b1;
                    o_cmd.k_rst    = 1'b1;
                    n_state = S_MMV;
                end
            end
            S_MMV: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_MOVE;
                n_state = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIVW;
            end
            S_DIVW: begin
                if (!i_sts.div_busy) begin
                    o_cmd.div_store = 1'b1;
                    if (i_sts.k_last) begin
                        o_cmd.st_en  = 1'b1;
                        o_cmd.st_val = ST_MOVED;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state = S_MMV;
                    end
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/wfs_dp.sv
`timescale 1ns / 1ps
module wfs_dp import wfs_pkg::*; #(
    parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [CMD_W-1:0]     i_cmd_code,
    input  logic [COORD_W-1:0]   i_coord_x,
    input  logic [COORD_W-1:0]   i_coord_y,
    input  logic [COORD_W-1:0]   i_coord_z,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [COORD_W-1:0]   o_new_x,
    output logic [COORD_W-1:0]   o_new_y,
    output logic [COORD_W-1:0]   o_new_z,
    output logic [ST_W-1:0]      o_status,
    output logic [IDX_OUT_W-1:0] o_current_index,
    output logic                 o_path_active
);

    localparam int CW = $clog2(PATH_DEPTH + 1);
    localparam int AW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;

    logic [3*COORD_W-1:0] r_mem [PATH_DEPTH];
    logic [3*COORD_W-1:0] r_wp;

    logic [CFG_W-1:0]   r_radius, r_speed, r_tick;
    logic [CW-1:0]      r_count, r_index;
    logic               r_has;
    logic [CMD_W-1:0]   r_cmd;
    logic [COORD_W-1:0] r_cur [3];
    logic [COORD_W-1:0] r_res [3];
    logic [AD_W-1:0]    r_ad  [3];
    logic               r_neg [3];
    logic [1:0]         r_k;
    logic [PROD_W-1:0]  r_prod;
    logic [DSQ_W-1:0]   r_dsq;
    logic [ROOT_W-1:0]  r_step;
    logic [ST_W-1:0]    r_st;

    logic                 r_ovalid;
    logic [COORD_W-1:0]   r_ox, r_oy, r_oz;
    logic [ST_W-1:0]      r_ost;
    logic [IDX_OUT_W-1:0] r_oidx;
    logic                 r_oact;

    logic [OP_W-1:0]   w_a, w_b;
    logic [ROOT_W-1:0] w_root, w_quo;
    logic              w_sq_busy, w_div_busy;
    logic [STEP_W-1:0] w_step;
    logic [COORD_W:0]  w_d [3];
    logic [COORD_W-1:0] w_wp [3];
    logic [CW:0]       w_idx_nx;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_speed  <= SPEED_RST;
            r_tick   <= TICK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RADIUS: r_radius <= i_cfg_wdata;
                REG_SPEED:  r_speed  <= i_cfg_wdata;
                REG_TICK:   r_tick   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // waypoint store
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_append) r_mem[r_count[AW-1:0]] <= {r_cur[0], r_cur[1], r_cur[2]};
        if (i_cmd.rd_wp)     r_wp <= r_mem[r_index[AW-1:0]];
    end

    // path state
    assign w_idx_nx = {1'b0, r_index} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_index <= '0;
            r_has   <= 1'b0;
        end else if (i_cmd.do_clear) begin
            r_count <= '0;
            r_index <= '0;
            r_has   <= 1'b0;
        end else begin
            if (i_cmd.do_append) begin
                r_count <= r_count + 1'b1;
                r_has   <= 1'b1;
            end
            if (i_cmd.idx_inc) r_index <= w_idx_nx[CW-1:0];
        end
    end

    // per-axis difference
    assign w_wp[0] = r_wp[3*COORD_W-1 -: COORD_W];
    assign w_wp[1] = r_wp[2*COORD_W-1 -: COORD_W];
    assign w_wp[2] = r_wp[COORD_W-1:0];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d[k] = {w_wp[k][COORD_W-1], w_wp[k]} - {r_cur[k][COORD_W-1], r_cur[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd    <= i_cmd_code;
            r_cur[0] <= i_coord_x;
            r_cur[1] <= i_coord_y;
            r_cur[2] <= i_coord_z;
        end
        if (i_cmd.lat_diff) begin
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= w_d[k][COORD_W];
                r_ad[k]  <= w_d[k][COORD_W] ? AD_W'(-w_d[k]) : w_d[k][AD_W-1:0];
            end
        end
    end

    // axis counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.k_rst)      r_k <= 2'd0;
        else if (i_cmd.k_inc) r_k <= r_k + 1'b1;
    end

    // shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SQ: begin
                w_a = OP_W'(r_ad[r_k]);
                w_b = OP_W'(r_ad[r_k]);
            end
            MUL_R2: begin
                w_a = OP_W'(r_radius);
                w_b = OP_W'(r_radius);
            end
            MUL_STEP: begin
                w_a = OP_W'(r_speed);
                w_b = OP_W'(r_tick);
            end
            default: begin
                w_a = OP_W'(r_ad[r_k]);
                w_b = r_step;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) r_prod <= w_a * w_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.k_rst && i_cmd.rd_wp) r_dsq <= '0;
        else if (i_cmd.acc_en)          r_dsq <= r_dsq + r_prod[DSQ_W-1:0];
    end

    wfs_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_val   (r_dsq),
        .o_busy  (w_sq_busy),
        .o_root  (w_root)
    );

    // clamp step to distance
    assign w_step = r_prod[STEP_HI:16];

    always_ff @(posedge i_clk) begin
        if (i_cmd.clamp_en) begin
            r_step <= (w_step > STEP_W'(w_root)) ? w_root : w_step[ROOT_W-1:0];
        end
    end

    wfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (w_root),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // result coordinates: echo input unless moved
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_res[0] <= i_coord_x;
            r_res[1] <= i_coord_y;
            r_res[2] <= i_coord_z;
        end else if (i_cmd.div_store) begin
            r_res[r_k] <= r_neg[r_k] ? r_cur[r_k] - w_quo[COORD_W-1:0]
                                     : r_cur[r_k] + w_quo[COORD_W-1:0];
        end
        if (i_cmd.st_en) r_st <= i_cmd.st_val;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ox   <= r_res[0];
            r_oy   <= r_res[1];
            r_oz   <= r_res[2];
            r_ost  <= r_st;
            r_oidx <= IDX_OUT_W'(r_index);
            r_oact <= r_has;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_new_x         = r_ox;
    assign o_new_y         = r_oy;
    assign o_new_z         = r_oz;
    assign o_status        = r_ost;
    assign o_current_index = r_oidx;
    assign o_path_active   = r_oact;

    assign o_sts.cmd        = r_cmd;
    assign o_sts.has_path   = r_has;
    assign o_sts.full       = (r_count >= CW'(PATH_DEPTH));
    assign o_sts.idx_ge_cnt = (r_index >= r_count);
    assign o_sts.reached    = ({{(PROD_W-DSQ_W){1'b0}}, r_dsq} <= r_prod);
    assign o_sts.last       = (w_idx_nx >= {1'b0, r_count});
    assign o_sts.k_last     = (r_k == 2'd2);
    assign o_sts.sqrt_busy  = w_sq_busy;
    assign o_sts.div_busy   = w_div_busy;
    assign o_sts.out_busy   = r_ovalid && !i_ready;

endmodule

### rtl/waypoint_follow_step_unit.sv
`timescale 1ns / 1ps
// channel  | handshake         | payload
// ---------+-------------------+---------------------------------------------
// in       | i_valid / o_ready | i_cmd, i_coord_x, i_coord_y, i_coord_z
// out      | o_valid / i_ready | o_new_x/y/z, o_status, o_current_index,
//          |                   | o_path_active
// config   | i_cfg_we          | i_cfg_idx, i_cfg_wdata
//
// One word at a time. Clear, append and ticks that end without motion go
// from decode straight to the output state; a reach decision first sums
// the squared distances; a move also runs the 34-step square root and three
// 34-step divides one after another on one divider, with the shared multiplier.
// Reset is synchronous, active low; the waypoint store is not cleared.
// A finished word waits in the output register while the next is accepted.
module waypoint_follow_step_unit import wfs_pkg::*; #(
    parameter int PATH_DEPTH = PATH_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [CMD_W-1:0]            i_cmd,
    input  logic signed [COORD_W-1:0]   i_coord_x,
    input  logic signed [COORD_W-1:0]   i_coord_y,
    input  logic signed [COORD_W-1:0]   i_coord_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [COORD_W-1:0]   o_new_x,
    output logic signed [COORD_W-1:0]   o_new_y,
    output logic signed [COORD_W-1:0]   o_new_z,
    output logic [ST_W-1:0]             o_status,
    output logic [IDX_OUT_W-1:0]        o_current_index,
    output logic                        o_path_active,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_wdata
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequence the steps of each word
    wfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // hold path state, store, arithmetic and the output register
    wfs_dp #(
        .PATH_DEPTH (PATH_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cmd_code      (i_cmd),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_new_x         (o_new_x),
        .o_new_y         (o_new_y),
        .o_new_z         (o_new_z),
        .o_status        (o_status),
        .o_current_index (o_current_index),
        .o_path_active   (o_path_active)
    );

    a_move_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_MOVED |-> o_path_active)
        else $error("moved word without an active path");

    a_clear_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_CLEARED |-> !o_path_active && o_current_index == '0)
        else $error("cleared word reports leftover path state");

    a_out_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> !(o_valid && !i_ready))
        else $error("output register overwritten while stalled");

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second word taken while one is in work");

endmodule
